// File: rtl/core/sef_pkg.sv
// Shared types and constants for the silhouette edge finder.
package sef_pkg;

  localparam int SEF_MAX_VERTICES = 64;
  localparam int COORD_W          = 16;
  localparam int INDEX_W          = 6;
  localparam int CFG_IDX_W        = 1;
  localparam int PROD_W           = 35;  // 17-bit normal times 18-bit doubled offset

  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 1'd1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [INDEX_W-1:0]        index_t;

  // Per-item control carried down the pipe.
  typedef struct packed {
    logic   last;      // final vertex of the hull
    logic   first_v;   // vertex 0 of the hull
    logic   second_v;  // vertex 1 of the hull
    index_t idx;       // index of this vertex
    index_t idx_m1;    // index of the previous vertex
  } sef_ctrl_t;

  typedef struct packed {
    sef_ctrl_t ctrl;
    coord_t    vx;
    coord_t    vy;
    coord_t    px;
    coord_t    py;
    coord_t    fx;
    coord_t    fy;
  } sef_vtx_t;

  // Partial products of both edge tests: edge into this vertex and closing edge.
  typedef struct packed {
    sef_ctrl_t ctrl;
    prod_t     e_nx;
    prod_t     e_ny;
    prod_t     c_nx;
    prod_t     c_ny;
  } sef_prod_t;

endpackage

// File: rtl/core/sef_if.sv
// Valid/ready channel interfaces for vertex items and result items.
interface sef_in_if import sef_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

interface sef_out_if import sef_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t start_index;
  index_t end_index;

  modport source (output valid, output start_index, output end_index, input ready);
  modport sink (input valid, input start_index, input end_index, output ready);
endinterface

// File: rtl/core/sef_front.sv
// Input stage: vertex counter, first and previous vertex, input register.
module sef_front import sef_pkg::*; #(
  parameter int MAX_VERTICES = SEF_MAX_VERTICES
) (
  input  logic        clk,
  input  logic        rst_n,
  sef_in_if.sink      in_ch,
  input  logic        s2_free,
  output logic        v1,
  output sef_vtx_t    s1
);

  localparam int CNT_W = $clog2(MAX_VERTICES);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  coord_t           first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  coord_t           prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic             v1_r, v1_nxt;
  sef_vtx_t         s1_r, s1_nxt;
  logic             accept;
  logic             is_first;

  assign in_ch.ready = !v1_r || s2_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_first    = (cnt_r == '0);

  always_comb begin
    cnt_nxt     = cnt_r;
    first_x_nxt = first_x_r;
    first_y_nxt = first_y_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    s1_nxt      = s1_r;
    v1_nxt      = v1_r;
    if (accept) begin
      v1_nxt               = 1'b1;
      s1_nxt.vx            = in_ch.vertex_x;
      s1_nxt.vy            = in_ch.vertex_y;
      s1_nxt.px            = prev_x_r;
      s1_nxt.py            = prev_y_r;
      s1_nxt.fx            = is_first ? in_ch.vertex_x : first_x_r;
      s1_nxt.fy            = is_first ? in_ch.vertex_y : first_y_r;
      s1_nxt.ctrl.last     = in_ch.last_vertex;
      s1_nxt.ctrl.first_v  = is_first;
      s1_nxt.ctrl.second_v = (cnt_r == CNT_W'(1));
      s1_nxt.ctrl.idx      = INDEX_W'(cnt_r);
      s1_nxt.ctrl.idx_m1   = INDEX_W'(CNT_W'(cnt_r - 1'b1));
      if (in_ch.last_vertex) begin
        // hull done: start over
        cnt_nxt     = '0;
        first_x_nxt = '0;
        first_y_nxt = '0;
        prev_x_nxt  = '0;
        prev_y_nxt  = '0;
      end else begin
        if (is_first) begin
          first_x_nxt = in_ch.vertex_x;
          first_y_nxt = in_ch.vertex_y;
        end
        prev_x_nxt = in_ch.vertex_x;
        prev_y_nxt = in_ch.vertex_y;
        if (cnt_r < CNT_W'(MAX_VERTICES - 1)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end else if (s2_free) begin
      v1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      v1_r      <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      first_x_r <= first_x_nxt;
      first_y_r <= first_y_nxt;
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
      v1_r      <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign v1 = v1_r;
  assign s1 = s1_r;

endmodule

// File: rtl/core/sef_edge.sv
// Product stage: light registers and the partial products of both edge tests.
module sef_edge import sef_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic                 v1,
  input  sef_vtx_t             s1,
  input  logic                 out_free,
  output logic                 s2_free,
  output logic                 fire2,
  output sef_prod_t            s2
);

  coord_t    light_x_r, light_y_r;
  logic      v2_r, v2_nxt;
  sef_prod_t s2_r, s2_nxt;
  logic      take1;

  logic signed [16:0] e_nx, e_ny, c_nx, c_ny;
  logic signed [17:0] e_dx, e_dy, c_dx, c_dy;
  logic [17:0]        lx2, ly2;

  // Only a final vertex needs room in the result register.
  assign fire2   = v2_r && (!s2_r.ctrl.last || out_free);
  assign s2_free = !v2_r || fire2;
  assign take1   = v1 && s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= '0;
      light_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT_X: light_x_r <= cfg_data;
        CFG_LIGHT_Y: light_y_r <= cfg_data;
      endcase
    end
  end

  // N = (a.y - b.y, b.x - a.x), D = 2*light - (a + b)
  always_comb begin
    lx2  = {light_x_r[15], light_x_r, 1'b0};
    ly2  = {light_y_r[15], light_y_r, 1'b0};
    // edge prev -> this vertex
    e_nx = {s1.py[15], s1.py} - {s1.vy[15], s1.vy};
    e_ny = {s1.vx[15], s1.vx} - {s1.px[15], s1.px};
    e_dx = lx2 - ({{2{s1.px[15]}}, s1.px} + {{2{s1.vx[15]}}, s1.vx});
    e_dy = ly2 - ({{2{s1.py[15]}}, s1.py} + {{2{s1.vy[15]}}, s1.vy});
    // closing edge this vertex -> first
    c_nx = {s1.vy[15], s1.vy} - {s1.fy[15], s1.fy};
    c_ny = {s1.fx[15], s1.fx} - {s1.vx[15], s1.vx};
    c_dx = lx2 - ({{2{s1.vx[15]}}, s1.vx} + {{2{s1.fx[15]}}, s1.fx});
    c_dy = ly2 - ({{2{s1.vy[15]}}, s1.vy} + {{2{s1.fy[15]}}, s1.fy});
  end

  always_comb begin
    s2_nxt = s2_r;
    v2_nxt = v2_r;
    if (take1) begin
      v2_nxt      = 1'b1;
      s2_nxt.ctrl = s1.ctrl;
      s2_nxt.e_nx = prod_t'(e_nx) * prod_t'(e_dx);
      s2_nxt.e_ny = prod_t'(e_ny) * prod_t'(e_dy);
      s2_nxt.c_nx = prod_t'(c_nx) * prod_t'(c_dx);
      s2_nxt.c_ny = prod_t'(c_ny) * prod_t'(c_dy);
    end else if (fire2) begin
      v2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign s2 = s2_r;

endmodule

// File: rtl/core/sef_track.sv
// Result stage: facing signs, transition tracking and the result register.
module sef_track import sef_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire2,
  input  sef_prod_t s2,
  output logic      out_free,
  sef_out_if.source out_ch
);

  logic   first_back_r, first_back_nxt;
  logic   prev_back_r, prev_back_nxt;
  index_t run_start_r, run_start_nxt;
  index_t run_end_r, run_end_nxt;
  logic   out_valid_r, out_valid_nxt;
  index_t out_start_r, out_start_nxt;
  index_t out_end_r, out_end_nxt;

  logic signed [PROD_W:0] e_sum, c_sum;
  logic                   e_back, c_back;
  logic                   fb, pb;
  index_t                 rs, re;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    e_sum  = (PROD_W+1)'(s2.e_nx) + (PROD_W+1)'(s2.e_ny);
    c_sum  = (PROD_W+1)'(s2.c_nx) + (PROD_W+1)'(s2.c_ny);
    // zero counts as facing the light
    e_back = !e_sum[PROD_W] && (e_sum != '0);
    c_back = !c_sum[PROD_W] && (c_sum != '0);

    fb = first_back_r;
    pb = prev_back_r;
    rs = run_start_r;
    re = run_end_r;

    if (s2.ctrl.first_v) begin
      rs = '0;
      re = '0;
    end else begin
      if (s2.ctrl.second_v) begin
        fb = e_back;
      end else begin
        if (pb && !e_back) re = s2.ctrl.idx_m1;
        if (!pb && e_back) rs = s2.ctrl.idx_m1;
      end
      pb = e_back;
    end

    if (s2.ctrl.last) begin
      if (s2.ctrl.first_v) begin
        fb = c_back;
      end else begin
        if (pb && !c_back) re = s2.ctrl.idx;
        if (!pb && c_back) rs = s2.ctrl.idx;
      end
      // wrap from closing edge to edge 0
      if (c_back && !fb) re = '0;
      if (!c_back && fb) rs = '0;
    end

    first_back_nxt = first_back_r;
    prev_back_nxt  = prev_back_r;
    run_start_nxt  = run_start_r;
    run_end_nxt    = run_end_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (fire2) begin
      if (s2.ctrl.last) begin
        out_valid_nxt  = 1'b1;
        out_start_nxt  = rs;
        out_end_nxt    = re;
        first_back_nxt = 1'b0;
        prev_back_nxt  = 1'b0;
        run_start_nxt  = '0;
        run_end_nxt    = '0;
      end else begin
        first_back_nxt = fb;
        prev_back_nxt  = pb;
        run_start_nxt  = rs;
        run_end_nxt    = re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_back_r <= 1'b0;
      prev_back_r  <= 1'b0;
      run_start_r  <= '0;
      run_end_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      first_back_r <= first_back_nxt;
      prev_back_r  <= prev_back_nxt;
      run_start_r  <= run_start_nxt;
      run_end_r    <= run_end_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.start_index = out_start_r;
  assign out_ch.end_index   = out_end_r;

endmodule

// File: rtl/core/silhouette_edge_finder.sv
// Top level of the silhouette edge finder for a convex hull and a point light.
//
//   port     dir  handshake      carries
//   in_ch    in   valid/ready    vertex_x, vertex_y, last_vertex
//   out_ch   out  valid/ready    start_index, end_index (on a last vertex only)
//   cfg_*    in   cfg_we         light_x (index 0), light_y (index 1)
//
// One vertex item per cycle unless a waiting result stalls the pipe; a result passes through
// the input register, product register and result register after its last vertex is accepted.
// Four 17x18 products per item run in parallel in the product stage.
// Synchronous active-low reset clears the light, hull state, run indices and valid bits.
// A waiting result holds a last vertex in the product register; one more vertex waits
// in the input register and the input then stalls until the result is taken.
module silhouette_edge_finder import sef_pkg::*; #(
  parameter int MAX_VERTICES = SEF_MAX_VERTICES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sef_in_if.sink               in_ch,
  sef_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  logic      v1;
  sef_vtx_t  s1;
  logic      s2_free;
  logic      fire2;
  sef_prod_t s2;
  logic      out_free;

  sef_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .s2_free (s2_free),
    .v1      (v1),
    .s1      (s1)
  );

  sef_edge u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .v1        (v1),
    .s1        (s1),
    .out_free  (out_free),
    .s2_free   (s2_free),
    .fire2     (fire2),
    .s2        (s2)
  );

  sef_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire2    (fire2),
    .s2       (s2),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule
